>>> src/sparse_block_vector_alu_core_assert.svh
// Assertion macros shared by the sparse block vector ALU RTL.
`ifndef SPARSE_BLOCK_VECTOR_ALU_CORE_ASSERT_SVH
`define SPARSE_BLOCK_VECTOR_ALU_CORE_ASSERT_SVH

// Check cons in the cycle after ante, outside reset.
`define SBVA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbva: next-cycle check failed");

// Check cons in the same cycle as ante, outside reset.
`define SBVA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbva: same-cycle check failed");

`endif

>>> src/sbva_pkg.sv
// Types and constants shared by the sparse block vector ALU modules.
`default_nettype none

package sbva_pkg;

  typedef enum logic [1:0] {
    OP_BIND   = 2'd0,
    OP_UNBIND = 2'd1,
    OP_ROTATE = 2'd2,
    OP_MATCH  = 2'd3
  } op_t;

  localparam logic [8:0] COUNT_MAX = 9'd511;

  typedef struct packed {
    op_t                operation;
    logic [7:0]         position;
    logic [5:0]         block_a;
    logic [5:0]         block_b;
    logic signed [15:0] shift;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [7:0] position_out;
    logic [5:0] block_out;
    logic [8:0] match_count;
    logic       last_out;
  } result_t;

endpackage

`default_nettype wire

>>> src/sbva_op_unit.sv
// Combinational block operation: bind, unbind, rotate and match count.
`default_nettype none

module sbva_op_unit import sbva_pkg::*; #(
  parameter int BLOCKS     = 256,
  parameter int BLOCK_SIZE = 64
) (
  input  item_t      item,
  input  logic [8:0] equal_count,
  output result_t    res,
  output logic [8:0] count_next
);

  localparam int BW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int PW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;

  // Residue tables, built at elaboration.
  logic [BW-1:0] bmod_tbl [64];
  logic [PW-1:0] pmod_tbl [256];
  logic [PW-1:0] shi_tbl  [256];
  logic [PW-1:0] slo_tbl  [256];

  for (genvar i = 0; i < 64; i++) begin : g_bmod
    assign bmod_tbl[i] = BW'(i % BLOCK_SIZE);
  end

  for (genvar i = 0; i < 256; i++) begin : g_pmod
    // High shift byte carries the sign: value is (signed byte) * 256.
    localparam int HS = (i >= 128) ? i - 256 : i;
    localparam int HM = ((HS * 256) % BLOCKS + BLOCKS) % BLOCKS;
    assign pmod_tbl[i] = PW'(i % BLOCKS);
    assign shi_tbl[i]  = PW'(HM);
    assign slo_tbl[i]  = PW'(i % BLOCKS);
  end

  logic [BW-1:0] a_mod;
  logic [BW-1:0] b_mod;
  logic [BW:0]   bsum;
  logic [BW:0]   bdiff;
  logic [BW-1:0] bind_blk;
  logic [BW-1:0] unbind_blk;
  logic [PW:0]   ssum;
  logic [PW-1:0] shift_mod;
  logic [PW:0]   psum;
  logic [PW-1:0] rot_pos;
  logic [8:0]    count_inc;

  always_comb begin
    a_mod = bmod_tbl[item.block_a];
    b_mod = bmod_tbl[item.block_b];

    bsum = {1'b0, a_mod} + {1'b0, b_mod};
    if (bsum >= (BW+1)'(BLOCK_SIZE)) begin
      bind_blk = BW'(bsum - (BW+1)'(BLOCK_SIZE));
    end else begin
      bind_blk = BW'(bsum);
    end

    // Wrap a negative difference back into range.
    bdiff = {1'b0, a_mod} - {1'b0, b_mod};
    if (a_mod >= b_mod) begin
      unbind_blk = BW'(bdiff);
    end else begin
      unbind_blk = BW'(bdiff + (BW+1)'(BLOCK_SIZE));
    end

    ssum = {1'b0, shi_tbl[item.shift[15:8]]} + {1'b0, slo_tbl[item.shift[7:0]]};
    if (ssum >= (PW+1)'(BLOCKS)) begin
      shift_mod = PW'(ssum - (PW+1)'(BLOCKS));
    end else begin
      shift_mod = PW'(ssum);
    end

    psum = {1'b0, pmod_tbl[item.position]} + {1'b0, shift_mod};
    if (psum >= (PW+1)'(BLOCKS)) begin
      rot_pos = PW'(psum - (PW+1)'(BLOCKS));
    end else begin
      rot_pos = PW'(psum);
    end

    // Saturate the running count.
    if ((item.block_a == item.block_b) && (equal_count != COUNT_MAX)) begin
      count_inc = equal_count + 9'd1;
    end else begin
      count_inc = equal_count;
    end

    res.position_out = item.position;
    res.block_out    = 6'd0;
    res.match_count  = 9'd0;
    res.last_out     = item.last;
    count_next       = equal_count;

    unique case (item.operation)
      OP_BIND: begin
        res.block_out = 6'(bind_blk);
      end
      OP_UNBIND: begin
        res.block_out = 6'(unbind_blk);
      end
      OP_ROTATE: begin
        res.position_out = 8'(rot_pos);
        res.block_out    = item.block_a;
      end
      OP_MATCH: begin
        res.match_count = count_inc;
        count_next      = item.last ? 9'd0 : count_inc;
      end
      default: begin
        res.block_out = 6'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/sparse_block_vector_alu_core.sv
// Top level of the sparse block vector ALU: input register, operation, result register.
//
//   channel  valid         stall         payload
//   item     item_valid    item_stall    operation position block_a block_b shift last
//   result   result_valid  result_stall  position_out block_out match_count last_out
//
// One item per cycle sustained while result_stall stays low; each item passes the input
// register, then the result register, before its result can transfer.
// rst is synchronous and clears both valid flags and the running match count.
// A stalled result holds; the input register still takes one more item behind it.
// item_stall rises only when both registers hold items and result_stall is high.
`default_nettype none

module sparse_block_vector_alu_core import sbva_pkg::*; #(
  parameter int BLOCKS     = 256,
  parameter int BLOCK_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         operation,
  input  logic [7:0]         position,
  input  logic [5:0]         block_a,
  input  logic [5:0]         block_b,
  input  logic signed [15:0] shift,
  input  logic               last,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [7:0]         position_out,
  output logic [5:0]         block_out,
  output logic [8:0]         match_count,
  output logic               last_out
);

  `include "sparse_block_vector_alu_core_assert.svh"

  logic       s1_valid;
  item_t      s1;
  logic [8:0] equal_count;
  logic [8:0] equal_count_next;
  result_t    res;
  logic       out_free;
  logic       advance;

  assign out_free   = !result_valid || !result_stall;
  assign advance    = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;

  sbva_op_unit #(
    .BLOCKS     (BLOCKS),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_op (
    .item        (s1),
    .equal_count (equal_count),
    .res         (res),
    .count_next  (equal_count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      equal_count  <= 9'd0;
    end else begin
      if (!item_stall) begin
        s1_valid <= item_valid;
      end
      if (out_free) begin
        result_valid <= s1_valid;
      end
      if (advance) begin
        equal_count <= equal_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1 <= '{operation: op_t'(operation), position: position, block_a: block_a,
              block_b: block_b, shift: shift, last: last};
    end
    if (advance) begin
      position_out <= res.position_out;
      block_out    <= res.block_out;
      match_count  <= res.match_count;
      last_out     <= res.last_out;
    end
  end

  `SBVA_ASSERT_NEXT(a_count_clear, advance && s1.operation == OP_MATCH && s1.last, equal_count == 9'd0)
  `SBVA_ASSERT_NEXT(a_nonmatch_zero, advance && s1.operation != OP_MATCH, match_count == 9'd0)
  `SBVA_ASSERT_SAME(a_stall_full, item_stall, s1_valid && result_valid)
  `SBVA_ASSERT_NEXT(a_count_hold, s1_valid && !advance, $stable(equal_count))

endmodule

`default_nettype wire

>>> tb/tb_sparse_block_vector_alu_core.sv
// Self-checking testbench for sparse_block_vector_alu_core: bind, unbind, rotate and match count.
module tb_sparse_block_vector_alu_core;
  timeunit 1ns;
  timeprecision 1ps;
  import sbva_pkg::*;

  localparam int BLOCKS       = 256;
  localparam int BLOCK_SIZE   = 64;
  localparam int TOTAL_RANDOM = 1780;
  localparam int SAT_RUN      = 520;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  class block_result_checker;
    result_t    expected_blocks[$];
    logic [8:0] equal_count;
    int         errors;

    function new();
      equal_count = '0;
      errors = 0;
    endfunction

    // Advance the running match count and return the block this item should produce.
    function result_t compute_block_result(item_t it);
      result_t r;
      int      s;
      int      rot;
      r = '0;
      r.position_out = it.position;
      r.last_out = it.last;
      case (it.operation)
        OP_BIND: begin
          r.block_out = 6'((int'(it.block_a) % BLOCK_SIZE + int'(it.block_b) % BLOCK_SIZE)
                           % BLOCK_SIZE);
        end
        OP_UNBIND: begin
          r.block_out = 6'((int'(it.block_a) % BLOCK_SIZE + BLOCK_SIZE
                            - int'(it.block_b) % BLOCK_SIZE) % BLOCK_SIZE);
        end
        OP_ROTATE: begin
          s = int'($signed(it.shift));
          rot = s % BLOCKS;
          if (rot < 0) rot += BLOCKS;
          r.position_out = 8'((int'(it.position) % BLOCKS + rot) % BLOCKS);
          r.block_out = it.block_a;
        end
        default: begin
          // Compare raw values; hold at the ceiling instead of wrapping.
          if (it.block_a == it.block_b && equal_count < COUNT_MAX) equal_count++;
          r.match_count = equal_count;
          if (it.last) equal_count = '0;
        end
      endcase
      return r;
    endfunction

    function void note_item(item_t it);
      expected_blocks.push_back(compute_block_result(it));
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction

    task report(string what, int got, int want);
      $display("error at %0t: %s got %0d want %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (expected_blocks.size() == 0) begin
        report("result with nothing pending, position_out", got.position_out, -1);
      end else begin
        want = expected_blocks.pop_front();
        if (got.position_out !== want.position_out)
          report("position_out", got.position_out, want.position_out);
        if (got.block_out !== want.block_out)
          report("block_out", got.block_out, want.block_out);
        if (got.match_count !== want.match_count)
          report("match_count", got.match_count, want.match_count);
        if (got.last_out !== want.last_out)
          report("last_out", got.last_out, want.last_out);
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [1:0]         operation = '0;
  logic [7:0]         position = '0;
  logic [5:0]         block_a = '0;
  logic [5:0]         block_b = '0;
  logic signed [15:0] shift = '0;
  logic               last = 1'b0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [7:0]         position_out;
  logic [5:0]         block_out;
  logic [8:0]         match_count;
  logic               last_out;

  block_result_checker block_chk;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;
  int cycle_count = 0;

  sparse_block_vector_alu_core #(
    .BLOCKS     (BLOCKS),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .position     (position),
    .block_a      (block_a),
    .block_b      (block_b),
    .shift        (shift),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .position_out (position_out),
    .block_out    (block_out),
    .match_count  (match_count),
    .last_out     (last_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check the transfer at this edge, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      block_chk.check_result({position_out, block_out, match_count, last_out});
    if (stall_phase == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_phase = $urandom_range(20, 300);
    end
    stall_phase--;
    case (stall_mode)
      0:       result_stall <= 1'b0;
      1:       result_stall <= ($urandom_range(0, 3) == 0);
      2:       result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= (stall_phase % 4 != 0);
    endcase
  end

  function automatic item_t mk(op_t op, logic [7:0] pos, logic [5:0] a, logic [5:0] b,
                               logic signed [15:0] sh, logic lst);
    item_t it;
    it.operation = op;
    it.position = pos;
    it.block_a = a;
    it.block_b = b;
    it.shift = sh;
    it.last = lst;
    return it;
  endfunction

  function automatic item_t random_item();
    return mk(op_t'($urandom_range(0, 3)), 8'($urandom), 6'($urandom), 6'($urandom),
              16'($urandom), 1'($urandom));
  endfunction

  function automatic logic signed [15:0] pick_shift();
    case ($urandom_range(0, 3))
      0:       return 16'(int'($urandom_range(0, 600)) - 300);
      1:       return 16'($urandom);
      2:       return 16'(int'($urandom_range(0, 2047)) - 1024);
      default: begin
        case ($urandom_range(0, 5))
          0:       return -16'sd32768;
          1:       return 16'sd32767;
          2:       return -16'sd1;
          3:       return 16'sd256;
          4:       return -16'sd256;
          default: return 16'sd0;
        endcase
      end
    endcase
  endfunction

  task automatic drive_item(item_t it);
    item_valid <= 1'b1;
    operation <= it.operation;
    position <= it.position;
    block_a <= it.block_a;
    block_b <= it.block_b;
    shift <= it.shift;
    last <= it.last;
    do @(posedge clk); while (item_stall);
    block_chk.note_item(it);
  endtask

  // Send in bursts; drop valid only when a real gap follows.
  task automatic send(item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    drive_item(it);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (block_chk.pending() != 0);
  endtask

  initial begin
    int   sent;
    int   len;
    int   base;
    int   kind;
    bit   broken;
    op_t  op;
    logic [5:0] a;
    logic [5:0] b;
    logic signed [15:0] vec_shift;
    item_t it;

    block_chk = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send(mk(OP_BIND,   8'd0,   6'd0,  6'd0,  16'sd0, 1'b0));
    send(mk(OP_BIND,   8'd255, 6'd63, 6'd63, 16'sd0, 1'b0));
    send(mk(OP_BIND,   8'd17,  6'd63, 6'd1,  16'sd0, 1'b0));
    send(mk(OP_UNBIND, 8'd1,   6'd0,  6'd63, 16'sd0, 1'b0));
    send(mk(OP_UNBIND, 8'd2,   6'd63, 6'd0,  16'sd0, 1'b0));
    send(mk(OP_UNBIND, 8'd3,   6'd5,  6'd5,  16'sd0, 1'b0));
    send(mk(OP_ROTATE, 8'd255, 6'd42, 6'd0,  16'sd1, 1'b0));
    send(mk(OP_ROTATE, 8'd0,   6'd21, 6'd63, -16'sd1, 1'b0));
    send(mk(OP_ROTATE, 8'd10,  6'd63, 6'd0,  -16'sd32768, 1'b0));
    send(mk(OP_ROTATE, 8'd255, 6'd63, 6'd63, 16'sd32767, 1'b0));
    send(mk(OP_ROTATE, 8'd128, 6'd0,  6'd0,  16'sd0, 1'b1));
    send(mk(OP_ROTATE, 8'd3,   6'd9,  6'd0,  16'sd256, 1'b0));
    send(mk(OP_ROTATE, 8'd3,   6'd9,  6'd0,  -16'sd257, 1'b0));
    // A last on a non-match item must leave the running count alone.
    send(mk(OP_MATCH,  8'd0,   6'd7,  6'd7,  16'sd0, 1'b0));
    send(mk(OP_MATCH,  8'd1,   6'd63, 6'd63, 16'sd0, 1'b0));
    send(mk(OP_BIND,   8'd2,   6'd4,  6'd4,  16'sd0, 1'b1));
    send(mk(OP_ROTATE, 8'd3,   6'd4,  6'd4,  16'sd5, 1'b1));
    send(mk(OP_MATCH,  8'd4,   6'd0,  6'd63, 16'sd0, 1'b0));
    send(mk(OP_MATCH,  8'd5,   6'd0,  6'd0,  -16'sd1, 1'b1));
    send(mk(OP_MATCH,  8'd0,   6'd33, 6'd33, 16'sd0, 1'b1));
    send(mk(OP_MATCH,  8'd0,   6'd33, 6'd32, 16'sd0, 1'b1));
    send(mk(OP_UNBIND, 8'd255, 6'd63, 6'd63, -16'sd1, 1'b1));
    drain();

    // Long run of equal blocks pushes the count into saturation.
    for (int i = 0; i < SAT_RUN; i++) begin
      a = 6'($urandom);
      send(mk(OP_MATCH, 8'(i), a, a, pick_shift(), i == SAT_RUN - 1));
    end
    sent = SAT_RUN;

    while (sent < TOTAL_RANDOM) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        send(random_item());
        sent++;
      end else begin
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 256) : $urandom_range(1, 16);
        op = op_t'($urandom_range(0, 3));
        base = $urandom_range(0, 255);
        vec_shift = pick_shift();
        broken = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < len; i++) begin
          a = 6'($urandom);
          b = (op == OP_MATCH && $urandom_range(0, 9) < 6) ? a : 6'($urandom);
          it = mk(op, 8'(base + i), a, b, vec_shift, (i == len - 1) && !broken);
          if (broken && i == len / 2) it.operation = op_t'($urandom_range(0, 3));
          send(it);
          sent++;
        end
        if ($urandom_range(0, 29) == 0) drain();
      end
    end

    item_valid <= 1'b0;
    while (block_chk.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (block_chk.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
